FILE: design/hrhp_pkg.sv
// Package for the HTTP request host and path parser.
// Holds the transfer structs, the phase and result-kind enums, byte codes and the buffer budget.
// No dependencies; imported by http_request_host_path_parser.
package hrhp_pkg;

	// Buffer budget in bytes, shared by all lines of one request.
	localparam int BUF_BYTES = 8192;

	// Counter width holds any value up to BUF_BYTES - 1; sums need one bit more.
	localparam int CNT_W = $clog2(BUF_BYTES);
	localparam int SUM_W = CNT_W + 1;
	localparam logic [SUM_W-1:0] BUF_LIMIT = SUM_W'(BUF_BYTES - 1);

	// Byte codes used by the parser.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Length of the header tag "Host:".
	localparam logic [2:0] HOST_TAG_LEN = 3'd5;

	typedef enum logic [2:0] {
		PH_METHOD = 3'd0,
		PH_PATH   = 3'd1,
		PH_TAIL   = 3'd2,
		PH_HSTART = 3'd3,
		PH_HOTHER = 3'd4,
		PH_HLEAD  = 3'd5,
		PH_HVALUE = 3'd6,
		PH_DONE   = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PATH     = 2'd0,
		KIND_HOST     = 2'd1,
		KIND_REDIRECT = 2'd2,
		KIND_BAD      = 2'd3
	} kind_t;

	typedef struct packed {
		logic       new_request;
		logic       end_of_input;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		kind_t      output_kind;
		logic [7:0] out_byte;
	} res_t;

	// Character of "Host:" at a given match position.
	function automatic logic [7:0] host_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0:    ch = 8'h48; // 'H'
			3'd1:    ch = 8'h6F; // 'o'
			3'd2:    ch = 8'h73; // 's'
			3'd3:    ch = 8'h74; // 't'
			3'd4:    ch = 8'h3A; // ':'
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

FILE: design/http_request_host_path_parser.sv
// HTTP request host and path parser: one byte per transfer, path and host bytes out, one verdict.
// Top level and only module; depends on hrhp_pkg.
//
// The parser takes one request byte per cycle while the output is not stalled and keeps up
// with back-to-back transfers on both sides. A byte is captured in an input register, its
// phase update and budget check are done combinationally against the parser state, and any
// result lands in a result register, so a result passes through the input register and the
// result register before it is offered. A stall on the output holds the result register and,
// once the input register is also full, stalls the input. Path bytes and host bytes are sent
// as they arrive; a bad request verdict tells downstream to throw away what it was given for
// that request. After a verdict further bytes are ignored until a transfer with new_request
// set.
module http_request_host_path_parser
	import hrhp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_item,
	output logic res_valid,
	input  logic res_stall,
	output res_t res_item
);

	// Input register.
	logic valid_s1;
	req_t item_s1;

	// Parser state.
	phase_t           phase_q, phase_d;
	logic             cr_q, cr_d;
	logic [2:0]       pm_q, pm_d;
	logic [CNT_W-1:0] lb_q, lb_d;
	logic [CNT_W-1:0] ub_q, ub_d;
	logic             hf_q, hf_d;

	// Result register.
	logic res_valid_q;
	res_t res_q;

	// Combinational results of the current byte.
	logic             emit;
	res_t             res_d;
	logic             advance;
	phase_t           ph;
	logic             cr;
	logic [2:0]       pm;
	logic [CNT_W-1:0] lb;
	logic [CNT_W-1:0] ub;
	logic             hf;
	logic [SUM_W-1:0] pos;
	logic [SUM_W-1:0] total;
	logic [CNT_W-1:0] content;
	logic [SUM_W-1:0] new_used;
	logic [7:0]       b;

	// The held byte moves on whenever the result register is free or being emptied.
	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign req_stall = valid_s1 && !advance;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			item_s1 <= req_item;
		end
	end

	// Parser state register, updated once per byte that moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_METHOD;
			cr_q    <= 1'b0;
			pm_q    <= 3'd0;
			lb_q    <= '0;
			ub_q    <= '0;
			hf_q    <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			cr_q    <= cr_d;
			pm_q    <= pm_d;
			lb_q    <= lb_d;
			ub_q    <= ub_d;
			hf_q    <= hf_d;
		end
	end

	// Next state and result for the byte in the input register.
	always_comb begin
		b = item_s1.data_byte;
		if (item_s1.new_request) begin
			ph = PH_METHOD;
			cr = 1'b0;
			pm = 3'd0;
			lb = '0;
			ub = '0;
			hf = 1'b0;
		end else begin
			ph = phase_q;
			cr = cr_q;
			pm = pm_q;
			lb = lb_q;
			ub = ub_q;
			hf = hf_q;
		end

		pos      = {1'b0, lb} + SUM_W'(1);
		total    = {1'b0, ub} + pos;
		content  = cr ? lb - CNT_W'(1) : lb;
		new_used = {1'b0, ub} + {1'b0, content} + SUM_W'(1);

		phase_d = ph;
		cr_d    = cr;
		pm_d    = pm;
		lb_d    = lb;
		ub_d    = ub;
		hf_d    = hf;
		emit    = 1'b0;
		res_d   = '{output_kind: KIND_BAD, out_byte: 8'h00};

		priority if (item_s1.end_of_input) begin
			if (ph != PH_DONE) begin
				phase_d = PH_DONE;
				emit    = 1'b1;
			end
		end else if (ph == PH_DONE) begin
			// Bytes after a verdict are dropped.
		end else if ((cr && b != CH_LF) || b == CH_NUL) begin
			phase_d = PH_DONE;
			emit    = 1'b1;
		end else if ((b == CH_LF && total > BUF_LIMIT) ||
				(b != CH_LF && total >= BUF_LIMIT)) begin
			phase_d = PH_DONE;
			emit    = 1'b1;
		end else if (b == CH_CR) begin
			cr_d = 1'b1;
			lb_d = pos[CNT_W-1:0];
		end else if (b == CH_LF) begin
			// End of line: charge its content plus one to the budget.
			ub_d = new_used[CNT_W-1:0];
			lb_d = '0;
			cr_d = 1'b0;
			pm_d = 3'd0;
			priority if (ph == PH_METHOD || ph == PH_PATH) begin
				phase_d = PH_DONE;
				emit    = 1'b1;
			end else if (ph == PH_HSTART && content == '0) begin
				phase_d = PH_DONE;
				emit    = 1'b1;
				if (hf) begin
					res_d.output_kind = KIND_REDIRECT;
				end
			end else if (new_used >= BUF_LIMIT) begin
				phase_d = PH_DONE;
				emit    = 1'b1;
			end else begin
				phase_d = PH_HSTART;
			end
		end else begin
			lb_d = pos[CNT_W-1:0];
			unique case (ph)
				PH_METHOD: begin
					if (b == CH_SPACE) begin
						phase_d = PH_PATH;
					end
				end
				PH_PATH: begin
					if (b == CH_SPACE) begin
						phase_d = PH_TAIL;
					end else begin
						emit  = 1'b1;
						res_d = '{output_kind: KIND_PATH, out_byte: b};
					end
				end
				PH_HSTART: begin
					if (pm < HOST_TAG_LEN && b == host_char(pm)) begin
						pm_d = pm + 3'd1;
						if (pm_d == HOST_TAG_LEN) begin
							if (hf) begin
								phase_d = PH_DONE;
								emit    = 1'b1;
							end else begin
								hf_d    = 1'b1;
								phase_d = PH_HLEAD;
							end
						end
					end else begin
						phase_d = PH_HOTHER;
					end
				end
				PH_HLEAD: begin
					if (b != CH_SPACE && b != CH_TAB) begin
						phase_d = PH_HVALUE;
						emit    = 1'b1;
						res_d   = '{output_kind: KIND_HOST, out_byte: b};
					end
				end
				PH_HVALUE: begin
					emit  = 1'b1;
					res_d = '{output_kind: KIND_HOST, out_byte: b};
				end
				default: begin
					// Rest of the request line and other header lines only count bytes.
				end
			endcase
		end
	end

	// Result register: loaded when a byte moves on, emptied when its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= emit;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res_d;
		end
	end

	// A verdict waiting at the output means the parser has finished that request.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_q.output_kind == KIND_REDIRECT ||
			res_q.output_kind == KIND_BAD) |-> phase_q == PH_DONE)
		else $error("verdict held while parser still active");

	// While parsing, the budget used so far stays below the limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_DONE |-> ({1'b0, ub_q} + {1'b0, lb_q}) < BUF_LIMIT)
		else $error("buffer budget overrun while parsing");

	// A pending carriage return always counts in the line length.
	assert property (@(posedge clk) disable iff (!arst_n)
		cr_q && phase_q != PH_DONE |-> lb_q != '0)
		else $error("carriage return without line bytes");

	// Host value phases are only reached after a Host header was found.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HLEAD || phase_q == PH_HVALUE |-> hf_q)
		else $error("host value phase without host header");

	// The input is only stalled while a byte is held.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1)
		else $error("input stalled with empty input register");

endmodule
